// ===== rtl/mms_pkg.sv =====
// ----------------------------------------------------------------------------
// mms_pkg: shared constants and types
// sizes, status codes and the sample store write request for the statistics
// engine
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int S2_W   = SQ_W + ADDR_W;
  localparam int D_W    = 2 * SUM_W;
  localparam int DVD_W  = D_W + 16;
  localparam int DVS_W  = 2 * CNT_W;
  localparam int RT_W   = DVD_W / 2;
  localparam int MEAN_W = SAMPLE_BITS + 8;
  localparam int SD_W   = 24;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_EXCESS = 2'd2;

  typedef struct packed {
    logic                          en;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] data;
  } mms_wr_t;

endpackage

// ===== rtl/mean_median_stddev_engine.sv =====
// ----------------------------------------------------------------------------
// mean_median_stddev_engine: descriptive statistics over a set of samples
// loads signed samples one per request and, after the last one, returns the
// mean, the median and the sample standard deviation of the set
//
//   channel   handshake           ports
//   request   start & !busy       sample, is_last
//   result    done (one cycle)    mean_q8, median_value, stddev_q8, set_size,
//                                 status
//
// a sample request without is_last leaves busy low; a request with is_last
// raises busy for the median ranking over the sample ram, a bit-serial
// divider pass and, for count > 1, CNT_W multiply steps, a second divider
// pass and RT_W square root steps. reset is synchronous and empties the set;
// the ram needs no clearing. results cannot be stalled, done lasts one cycle
// ----------------------------------------------------------------------------
module mean_median_stddev_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [mms_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   is_last,
  output logic                                   done,
  output logic signed [mms_pkg::MEAN_W-1:0]      mean_q8,
  output logic signed [mms_pkg::SAMPLE_BITS-1:0] median_value,
  output logic [mms_pkg::SD_W-1:0]               stddev_q8,
  output logic [mms_pkg::CNT_W-1:0]              set_size,
  output logic [1:0]                             status
);
  import mms_pkg::*;

  localparam int K_W = $clog2(CNT_W);

  typedef enum logic [3:0] {
    S_IDLE, S_MED_GO, S_MED_WAIT, S_MEAN_GO, S_MEAN_WAIT, S_MUL, S_SUB,
    S_VAR_GO, S_VAR_WAIT, S_SQ_GO, S_SQ_WAIT, S_OUT
  } state_t;

  state_t state;

  logic [CNT_W-1:0]              count;
  logic signed [SUM_W-1:0]       sum;
  logic [S2_W-1:0]               s2;
  logic                          ovf;
  logic                          sq_v1;
  logic                          sq_v2;
  logic signed [SAMPLE_BITS-1:0] sq_x;
  logic [SQ_W-1:0]               sq_p;
  logic [D_W-1:0]                acc;
  logic [D_W-1:0]                s1sq;
  logic [D_W-1:0]                dvar;
  logic [K_W-1:0]                k;
  logic                          accept;
  logic                          store_ok;
  mms_wr_t                       wr;
  logic                          med_done;
  logic signed [SAMPLE_BITS-1:0] med;
  logic                          div_start;
  logic [DVD_W-1:0]              div_dvd;
  logic [DVS_W-1:0]              div_dvs;
  logic                          div_done;
  logic [DVD_W-1:0]              div_q;
  logic                          sq_done;
  logic [RT_W-1:0]               sq_root;
  logic [SUM_W-1:0]              sum_abs;
  logic signed [D_W-1:0]         sum_sq;
  logic [MEAN_W-1:0]             q_mean;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign store_ok = count < CNT_W'(MAX_SAMPLES);

  // store write request
  assign wr.en   = accept && store_ok;
  assign wr.addr = count[ADDR_W-1:0];
  assign wr.data = sample;

  assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign sum_sq  = sum * sum;
  assign q_mean  = div_q[MEAN_W-1:0];

  // divider operands: mean pass or variance pass
  assign div_start = (state == S_MEAN_GO) || (state == S_VAR_GO);
  assign div_dvd   = (state == S_MEAN_GO) ? (DVD_W'(sum_abs) << 8) : {dvar, 16'h0000};
  assign div_dvs   = (state == S_MEAN_GO) ? DVS_W'(count) :
                     DVS_W'(count) * DVS_W'(count - 1'b1);

  mms_median u_median (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .start  (state == S_MED_GO),
    .n      (count),
    .done   (med_done),
    .median (med)
  );

  mms_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  mms_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SQ_GO),
    .radicand (div_q),
    .done     (sq_done),
    .root     (sq_root)
  );

  // sum of squares pipeline, drained long before it is used
  always_ff @(posedge clk) begin
    sq_x <= sample;
    sq_p <= sq_x * sq_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      sum   <= '0;
      s2    <= '0;
      ovf   <= 1'b0;
      sq_v1 <= 1'b0;
      sq_v2 <= 1'b0;
      done  <= 1'b0;
    end else begin
      done  <= 1'b0;
      sq_v1 <= wr.en;
      sq_v2 <= sq_v1;
      if (sq_v2) begin
        s2 <= s2 + S2_W'(sq_p);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_ok) begin
              count <= count + 1'b1;
              sum   <= sum + SUM_W'(sample);
            end else begin
              ovf <= 1'b1;
            end
            if (is_last) begin
              state <= S_MED_GO;
            end
          end
        end
        S_MED_GO: state <= S_MED_WAIT;
        S_MED_WAIT: begin
          if (med_done) begin
            median_value <= med;
            state        <= S_MEAN_GO;
          end
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_q8 <= sum[SUM_W-1] ? MEAN_W'(-q_mean) : q_mean;
            acc     <= '0;
            k       <= '0;
            s1sq    <= D_W'(sum_sq);
            if (count == CNT_W'(1)) begin
              stddev_q8 <= '0;
              state     <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        // n * s2 by shift and add
        S_MUL: begin
          if (count[k]) begin
            acc <= acc + (D_W'(s2) << k);
          end
          if (k == K_W'(CNT_W - 1)) begin
            state <= S_SUB;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_SUB: begin
          dvar  <= acc - s1sq;
          state <= S_VAR_GO;
        end
        S_VAR_GO: state <= S_VAR_WAIT;
        S_VAR_WAIT: begin
          if (div_done) begin
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sq_done) begin
            stddev_q8 <= (sq_root > RT_W'({SD_W{1'b1}})) ? {SD_W{1'b1}} : SD_W'(sq_root);
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          done     <= 1'b1;
          set_size <= count;
          status   <= ovf ? ST_EXCESS : ((count == CNT_W'(1)) ? ST_SINGLE : ST_OK);
          count    <= '0;
          sum      <= '0;
          s2       <= '0;
          ovf      <= 1'b0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only follows the output step
  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_OUT))
    else $error("result strobe without output step");

  // a reported set is never empty
  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> set_size != '0)
    else $error("empty set reported");

  // a request into a full store marks the overflow
  a_full_flags: assert property (@(posedge clk) disable iff (rst)
    (accept && !store_ok) |=> ovf)
    else $error("dropped sample not flagged");

  // the store fill never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("store fill beyond capacity");

endmodule

// ===== rtl/mms_divider.sv =====
// ----------------------------------------------------------------------------
// mms_divider: restoring divider
// unsigned quotient, one bit per cycle, shared by the mean and the variance
// ----------------------------------------------------------------------------
module mms_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mms_pkg::DVD_W-1:0] dividend,
  input  logic [mms_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [mms_pkg::DVD_W-1:0] quotient
);
  import mms_pkg::*;

  localparam int C_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [C_W-1:0]   cnt;
  logic             run;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem, quotient[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= C_W'(DVD_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        if (fits) begin
          rem <= DVS_W'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[DVS_W-1:0];
        end
        quotient <= {quotient[DVD_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == C_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/mms_isqrt.sv =====
// ----------------------------------------------------------------------------
// mms_isqrt: integer square root
// floor of the root, one result bit per cycle from two radicand bits
// ----------------------------------------------------------------------------
module mms_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mms_pkg::DVD_W-1:0] radicand,
  output logic                      done,
  output logic [mms_pkg::RT_W-1:0]  root
);
  import mms_pkg::*;

  localparam int C_W = $clog2(RT_W + 1);

  logic [DVD_W-1:0] rad;
  logic [RT_W+1:0]  rem;
  logic [C_W-1:0]   cnt;
  logic             run;
  logic [RT_W+1:0]  rem_sh;
  logic [RT_W+1:0]  trial;
  logic             fits;

  // bring down two bits and try root*4+1
  assign rem_sh = {rem[RT_W-1:0], rad[DVD_W-1:DVD_W-2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= C_W'(RT_W);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (run) begin
        rad  <= {rad[DVD_W-3:0], 2'b00};
        rem  <= fits ? rem_sh - trial : rem_sh;
        root <= {root[RT_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == C_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/mms_median.sv =====
// ----------------------------------------------------------------------------
// mms_median: sample store and median finder
// holds the samples in a synchronous ram and finds the middle elements by
// ranking each entry against a scan of the filled part of the store
// ----------------------------------------------------------------------------
module mms_median (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mms_pkg::mms_wr_t                      wr,
  input  logic                                  start,
  input  logic [mms_pkg::CNT_W-1:0]             n,
  output logic                                  done,
  output logic signed [mms_pkg::SAMPLE_BITS-1:0] median
);
  import mms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_VREQ, S_VCAP, S_SCAN, S_TAIL, S_RANK, S_FIN
  } state_t;

  state_t state;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]             rd_addr;
  logic signed [SAMPLE_BITS-1:0] v;
  logic signed [SAMPLE_BITS-1:0] lo;
  logic signed [SAMPLE_BITS-1:0] hi;
  logic [ADDR_W-1:0]             i;
  logic [ADDR_W-1:0]             j;
  logic [ADDR_W-1:0]             jd;
  logic [ADDR_W-1:0]             n_last;
  logic [ADDR_W-1:0]             m_lo;
  logic [ADDR_W-1:0]             m_hi;
  logic [ADDR_W-1:0]             rank;
  logic                          cmp_valid;
  logic                          odd;
  logic                          below;
  logic [CNT_W-1:0]              n_m1;
  logic [CNT_W-1:0]              n_half;
  logic signed [SAMPLE_BITS:0]   pair;
  logic signed [SAMPLE_BITS:0]   pair_adj;

  assign rd_addr = (state == S_SCAN) ? j : i;
  assign n_m1    = n - 1'b1;
  assign n_half  = n >> 1;

  // entries that sort ahead of v, ties broken by position
  assign below = (rd_data < v) || ((rd_data == v) && (jd < i));

  // average of the two middles, truncated toward zero
  assign pair     = {lo[SAMPLE_BITS-1], lo} + {hi[SAMPLE_BITS-1], hi};
  assign pair_adj = pair + {{SAMPLE_BITS{1'b0}}, pair[SAMPLE_BITS]};

  // sample ram, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      done      <= 1'b0;
      cmp_valid <= (state == S_SCAN);
      jd        <= j;
      if (cmp_valid) begin
        rank <= rank + ADDR_W'(below);
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            i      <= '0;
            n_last <= n_m1[ADDR_W-1:0];
            odd    <= n[0];
            m_hi   <= n_half[ADDR_W-1:0];
            m_lo   <= n[0] ? n_half[ADDR_W-1:0] : ADDR_W'(n_half - 1'b1);
            state  <= S_VREQ;
          end
        end
        S_VREQ: begin
          state <= S_VCAP;
        end
        S_VCAP: begin
          v     <= rd_data;
          j     <= '0;
          rank  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (j == n_last) begin
            state <= S_TAIL;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_TAIL: begin
          state <= S_RANK;
        end
        S_RANK: begin
          if (rank == m_lo) begin
            lo <= v;
          end
          if (rank == m_hi) begin
            hi <= v;
          end
          if (i == n_last) begin
            state <= S_FIN;
          end else begin
            i     <= i + 1'b1;
            state <= S_VREQ;
          end
        end
        S_FIN: begin
          median <= odd ? hi : pair_adj[SAMPLE_BITS:1];
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
